>>> design/sba_pkg.sv
// Package for the segregated block allocator: block layout, sizes, status codes.
// Used by sba_tag_mem and segregated_block_allocator_unit.
package sba_pkg;
    localparam int NUM_CLASSES_D  = 6;
    localparam int NUM_BLOCKS_D   = 46;
    localparam int LARGE_BLOCKS_D = 12;
    localparam int TAG_WIDTH_D    = 16;

    localparam int REQ_W  = 16;
    localparam int SIZE_W = 9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_TAG = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // blocks per class; the last class is the large class
    function automatic int class_count(input int c);
        case (c)
            0: class_count = 4;
            1: class_count = 4;
            2: class_count = 8;
            3: class_count = 8;
            4: class_count = 10;
            5: class_count = 12;
            6: class_count = 4;
            default: class_count = 4;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] large_size(input int k);
        case (k)
            0, 1, 2:   large_size = 9'd40;
            3, 4, 5:   large_size = 9'd48;
            6, 7, 8:   large_size = 9'd64;
            9, 10:     large_size = 9'd128;
            11:        large_size = 9'd256;
            default:   large_size = 9'd0;
        endcase
    endfunction

    function automatic int class_base(input int c, input int nc);
        int s;
        s = 0;
        for (int i = 0; i < 8; i++)
            if (i < c)
                s += (i + 1 == nc) ? 0 : class_count(i);
        class_base = s;
    endfunction

    // size of block b, 0 beyond the layout
    function automatic logic [SIZE_W-1:0] blk_size(input int b, input int nc, input int nb);
        logic [SIZE_W-1:0] r;
        int base;
        r = '0;
        for (int c = 0; c < 8; c++) begin
            base = class_base(c, nc);
            if (c + 1 < nc) begin
                if (b >= base && b < base + class_count(c) && b < nb)
                    r = SIZE_W'(2 << c);
            end else if (c + 1 == nc) begin
                if (b >= base && b < base + class_count(c) && b < nb)
                    r = large_size(b - base);
            end
        end
        blk_size = r;
    endfunction
endpackage

>>> design/segregated_block_allocator_unit.sv
// Top level of the segregated block allocator: busy bits, large-list order,
// tag counter and the search sequencer. Depends on sba_pkg and sba_tag_mem.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+--------------------------
//  request | action, request_size, tag_in             | start high while busy low
//  result  | status, tag_out, granted_size            | done strobe, one cycle
//
// An allocate scans the busy bits one block a cycle. A free reads the tag memory one
// entry a cycle and compares; a freed large block then shifts the order list, one slot
// a cycle, with busy still high after the result strobe until the shift ends.
// Reset clears the busy bits, sets the order list to 0..LARGE_BLOCKS-1 and the tag
// counter to 1. Results cannot stall.
module segregated_block_allocator_unit
    import sba_pkg::*;
#(
    parameter int NUM_CLASSES  = NUM_CLASSES_D,
    parameter int NUM_BLOCKS   = NUM_BLOCKS_D,
    parameter int LARGE_BLOCKS = LARGE_BLOCKS_D,
    parameter int TAG_WIDTH    = TAG_WIDTH_D
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [REQ_W-1:0]     request_size,
    input  logic [TAG_WIDTH-1:0] tag_in,
    output logic                 done,
    output logic [1:0]           status,
    output logic [TAG_WIDTH-1:0] tag_out,
    output logic [SIZE_W-1:0]    granted_size
);
    localparam int BW = $clog2(NUM_BLOCKS + 1);
    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
    localparam int KW = $clog2(LARGE_BLOCKS + 1);
    localparam int LBASE = class_base(NUM_CLASSES - 1, NUM_CLASSES);
    localparam int FIXED = (LBASE < NUM_BLOCKS) ? LBASE : NUM_BLOCKS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIX   = 3'd1;
    localparam logic [2:0] S_LARGE = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [NUM_BLOCKS-1:0] busy_bits_reg, busy_bits_next;
    logic [LW-1:0]        order_reg [LARGE_BLOCKS];
    logic [TAG_WIDTH-1:0] next_tag_reg;
    logic [BW-1:0]        idx_reg, idx_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [AW-1:0]        rd_blk_reg, rd_blk_next;
    logic [REQ_W-1:0]     req_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [LW-1:0]        mtf_reg, mtf_next;
    logic                 shift_go;
    logic                 take;
    logic [AW-1:0]        take_blk;
    logic [TAG_WIDTH-1:0] tag_rd;
    logic [TAG_WIDTH-1:0] tag_inc;
    logic [SIZE_W-1:0]    size_tab [NUM_BLOCKS];
    logic                 done_next;
    logic [1:0]           status_next;
    logic [TAG_WIDTH-1:0] tag_out_next;
    logic [SIZE_W-1:0]    size_next;

    for (genvar b = 0; b < NUM_BLOCKS; b++) begin : g_size
        assign size_tab[b] = blk_size(b, NUM_CLASSES, NUM_BLOCKS);
    end

    assign tag_inc = next_tag_reg + 1'b1;

    sba_tag_mem #(.DEPTH(NUM_BLOCKS), .TW(TAG_WIDTH)) u_tags (
        .clk   (clk),
        .we    (take),
        .waddr (take_blk),
        .wdata (next_tag_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (tag_rd)
    );

    // size of the fixed block at idx: it must cover the request
    logic [SIZE_W-1:0] cur_size;
    logic [LW-1:0]     cur_j;
    logic [BW-1:0]     large_b;
    assign cur_size = (idx_reg < BW'(NUM_BLOCKS)) ? size_tab[idx_reg[AW-1:0]] : '0;
    assign cur_j    = order_reg[k_reg[LW-1:0]];
    assign large_b  = BW'(LBASE) + BW'(cur_j);

    always_comb
    begin
        state_next     = state_reg;
        busy_bits_next = busy_bits_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        rd_valid_next  = 1'b0;
        rd_blk_next    = idx_reg[AW-1:0];
        mtf_next       = mtf_reg;
        shift_go       = 1'b0;
        take           = 1'b0;
        take_blk       = idx_reg[AW-1:0];
        done_next      = 1'b0;
        status_next    = ST_OK;
        tag_out_next   = '0;
        size_next      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    k_next     = '0;
                    state_next = (action == ACT_FREE) ? S_FREE : S_FIX;
                end
            end
            S_FIX:
            begin
                if (idx_reg >= BW'(FIXED))
                    state_next = S_LARGE;
                else if (!busy_bits_reg[idx_reg[AW-1:0]] && {7'd0, cur_size} >= req_reg)
                begin
                    take         = 1'b1;
                    busy_bits_next[idx_reg[AW-1:0]] = 1'b1;
                    done_next    = 1'b1;
                    tag_out_next = next_tag_reg;
                    size_next    = cur_size;
                    state_next   = S_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_LARGE:
            begin
                if (k_reg >= KW'(LARGE_BLOCKS))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    state_next  = S_IDLE;
                end
                else if (large_b < BW'(NUM_BLOCKS) && !busy_bits_reg[large_b[AW-1:0]]
                         && {7'd0, size_tab[large_b[AW-1:0]]} >= req_reg)
                begin
                    take         = 1'b1;
                    take_blk     = large_b[AW-1:0];
                    busy_bits_next[large_b[AW-1:0]] = 1'b1;
                    done_next    = 1'b1;
                    tag_out_next = next_tag_reg;
                    size_next    = size_tab[large_b[AW-1:0]];
                    state_next   = S_IDLE;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_FREE:
            begin
                // idx issues a read; the compare runs in the next cycle
                if (rd_valid_reg && busy_bits_reg[rd_blk_reg] && tag_rd == tag_reg)
                begin
                    busy_bits_next[rd_blk_reg] = 1'b0;
                    done_next  = 1'b1;
                    size_next  = size_tab[rd_blk_reg];
                    state_next = S_IDLE;
                    if ({1'b0, rd_blk_reg} >= (AW+1)'(LBASE))
                    begin
                        mtf_next   = LW'(rd_blk_reg - AW'(LBASE));
                        k_next     = KW'(LARGE_BLOCKS - 1);
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg >= BW'(NUM_BLOCKS))
                begin
                    if (!rd_valid_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BAD_TAG;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    rd_valid_next = 1'b1;
                    rd_blk_next   = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // walk from the back: find the entry, then shift earlier ones up
                shift_go = 1'b1;
                if (k_reg == '0)
                    state_next = S_IDLE;
                else
                    k_next = k_reg - 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    logic found_reg;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_bits_reg <= '0;
            next_tag_reg  <= TAG_WIDTH'(1);
            rd_valid_reg  <= 1'b0;
            done          <= 1'b0;
            found_reg     <= 1'b0;
            for (int i = 0; i < LARGE_BLOCKS; i++)
                order_reg[i] <= LW'(i);
        end
        else
        begin
            state_reg     <= state_next;
            busy_bits_reg <= busy_bits_next;
            rd_valid_reg  <= rd_valid_next;
            done          <= done_next;
            if (take)
                next_tag_reg <= (tag_inc == '0) ? TAG_WIDTH'(1) : tag_inc;
            if (state_next == S_SHIFT && state_reg != S_SHIFT)
                found_reg <= 1'b0;
            if (shift_go)
            begin
                if (k_reg == '0)
                    order_reg[0] <= mtf_reg;
                else if (found_reg || order_reg[k_reg[LW-1:0]] == mtf_reg)
                begin
                    found_reg <= 1'b1;
                    order_reg[k_reg[LW-1:0]] <= order_reg[k_reg[LW-1:0] - 1'b1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        rd_blk_reg   <= rd_blk_next;
        mtf_reg      <= mtf_next;
        status       <= status_next;
        tag_out      <= tag_out_next;
        granted_size <= size_next;
        if (start && state_reg == S_IDLE)
        begin
            req_reg <= request_size;
            tag_reg <= tag_in;
        end
    end
endmodule

>>> design/sba_tag_mem.sv
// Tag store of the allocator: one entry per block, registered read.
// Depends on sba_pkg.
module sba_tag_mem
    import sba_pkg::*;
#(
    parameter int DEPTH = NUM_BLOCKS_D,
    parameter int TW    = TAG_WIDTH_D,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [TW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [TW-1:0] rdata
);
    logic [TW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> tb/tb_segregated_block_allocator_unit.sv
// Testbench for segregated_block_allocator_unit: directed and random allocate/free requests,
// checked against an in-bench allocator predictor. Depends on sba_pkg and the design files.
`timescale 1ns / 1ps

module tb_segregated_block_allocator_unit;
    import sba_pkg::*;

    localparam int NB = NUM_BLOCKS_D;
    localparam int NL = LARGE_BLOCKS_D;
    localparam int LBASE = 34;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       tag;
        logic [SIZE_W-1:0] size;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic action;
    logic [REQ_W-1:0] request_size;
    logic [15:0] tag_in;
    logic done;
    logic [1:0] status;
    logic [15:0] tag_out;
    logic [SIZE_W-1:0] granted_size;

    // predictor state
    bit          pool_busy [NB];
    logic [15:0] pool_tag [NB];
    logic [15:0] tag_counter;
    int          large_list [NL];
    logic [15:0] live_tags [$];

    alloc_result_t expected_results [$];
    int mismatches;
    int idle_cycles;
    bit timed_out;

    segregated_block_allocator_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .request_size(request_size), .tag_in(tag_in), .done(done), .status(status),
        .tag_out(tag_out), .granted_size(granted_size)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int block_units(input int b);
        int sizes [NL] = '{40, 40, 40, 48, 48, 48, 64, 64, 64, 128, 128, 256};
        if (b < 4) return 2;
        if (b < 8) return 4;
        if (b < 16) return 8;
        if (b < 24) return 16;
        if (b < LBASE) return 32;
        return sizes[b - LBASE];
    endfunction

    function automatic logic [15:0] claim_block(input int b);
        logic [15:0] t;
        t = tag_counter;
        pool_busy[b] = 1'b1;
        pool_tag[b] = t;
        tag_counter = t + 16'd1;
        if (tag_counter == 16'd0)
            tag_counter = 16'd1;
        return t;
    endfunction

    function automatic alloc_result_t predict_alloc(input logic act, input logic [15:0] req,
                                                    input logic [15:0] tg);
        alloc_result_t r;
        int bases [5] = '{0, 4, 8, 16, 24};
        int counts [5] = '{4, 4, 8, 8, 10};
        int b;
        int j;
        int p;
        bit found;
        r = '{ST_FULL, 16'd0, '0};
        found = 0;
        if (act == ACT_ALLOC) begin
            for (int c = 0; c < 5 && !found; c++) begin
                if (req > (2 << c))
                    continue;
                for (int k = 0; k < counts[c] && !found; k++) begin
                    b = bases[c] + k;
                    if (!pool_busy[b]) begin
                        r.tag = claim_block(b);
                        r.size = SIZE_W'(block_units(b));
                        found = 1;
                    end
                end
            end
            for (int k = 0; k < NL && !found; k++) begin
                b = LBASE + large_list[k];
                if (!pool_busy[b] && req <= block_units(b)) begin
                    r.tag = claim_block(b);
                    r.size = SIZE_W'(block_units(b));
                    found = 1;
                end
            end
            if (found) begin
                r.status = ST_OK;
                live_tags.push_back(r.tag);
            end
        end else begin
            r.status = ST_BAD_TAG;
            for (b = 0; b < NB && !found; b++) begin
                if (pool_busy[b] && pool_tag[b] == tg) begin
                    pool_busy[b] = 1'b0;
                    r.status = ST_OK;
                    r.size = SIZE_W'(block_units(b));
                    found = 1;
                    if (b >= LBASE) begin
                        j = b - LBASE;
                        p = 0;
                        while (large_list[p] != j)
                            p++;
                        for (; p > 0; p--)
                            large_list[p] = large_list[p - 1];
                        large_list[0] = j;
                    end
                end
            end
            if (found)
                foreach (live_tags[i])
                    if (live_tags[i] == tg) begin
                        live_tags.delete(i);
                        break;
                    end
        end
        return r;
    endfunction

    task automatic send_request(input logic act, input logic [15:0] req, input logic [15:0] tg);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        // busy rises right after an accept, so the first edge costs nothing
        repeat (gap + 1) @(posedge clk);
        start <= 1'b1;
        action <= act;
        request_size <= req;
        tag_in <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_alloc(act, req, tg));
        start <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic free_some(input int n);
        logic [15:0] t;
        int i;
        repeat (n)
        begin
            if (live_tags.size() == 0)
                break;
            i = $urandom_range(0, live_tags.size() - 1);
            t = live_tags[i];
            send_request(ACT_FREE, 16'd0, t);
        end
    endtask

    task automatic test_directed();
        send_request(ACT_ALLOC, 16'd0, 16'hFFFF);
        send_request(ACT_ALLOC, 16'd2, 16'd0);
        send_request(ACT_ALLOC, 16'd33, 16'd0);
        send_request(ACT_ALLOC, 16'd256, 16'd0);
        send_request(ACT_ALLOC, 16'd257, 16'd0);
        send_request(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(ACT_FREE, 16'hFFFF, 16'd0);
        send_request(ACT_FREE, 16'd0, 16'd1);
        send_request(ACT_FREE, 16'd0, 16'd1);
        send_request(ACT_FREE, 16'd0, 16'hFFFF);
        send_request(ACT_FREE, 16'd0, 16'd4);
        // exhaust the pool so empty classes are skipped and heap full is seen
        repeat (48) send_request(ACT_ALLOC, 16'd1, 16'd0);
        free_some(46);
        drain_results();
    endtask

    task automatic test_random(input int n);
        int kind;
        logic [15:0] req;
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                case ($urandom_range(0, 3))
                    0: req = 16'($urandom_range(0, 32));
                    1: req = 16'($urandom_range(33, 256));
                    2: req = 16'($urandom_range(0, 8));
                    default: req = 16'($urandom);
                endcase
                send_request(ACT_ALLOC, req, 16'($urandom));
            end else if (kind < 88 && live_tags.size() != 0) begin
                free_some(1);
            end else begin
                send_request(ACT_FREE, 16'($urandom), 16'($urandom));
            end
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d tag=%0d size=%0d",
                             status, tag_out, granted_size);
            end else begin
                e = expected_results.pop_front();
                if (status !== e.status || tag_out !== e.tag || granted_size !== e.size) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.status, e.tag, e.size, status, tag_out, granted_size);
                end
            end
        end
    end

    // watchdog: count cycles in which neither a request nor a result is accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[segregated_block_allocator_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = 1'b0;
        request_size = '0;
        tag_in = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        foreach (pool_busy[i])
        begin
            pool_busy[i] = 1'b0;
            pool_tag[i] = '0;
        end
        foreach (large_list[i])
            large_list[i] = i;
        tag_counter = 16'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[segregated_block_allocator_unit] OK");
        else
            $display("[segregated_block_allocator_unit] ERROR");
        $finish;
    end
endmodule
